>>> sv/utf8_stream_decoder_top_assert.svh
// Assertion macros used by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("utf8 decoder: next-cycle check failed");

`endif

>>> sv/utf8d_pkg.sv
// Types, constants and the lead-byte decode function of the UTF-8 stream decoder.
package utf8d_pkg;

	localparam int CP_W = 21;

	localparam logic [7:0] MASK_CONT = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] MASK_L2   = 8'hE0;
	localparam logic [7:0] TAG_L2    = 8'hC0;
	localparam logic [7:0] MASK_L3   = 8'hF0;
	localparam logic [7:0] TAG_L3    = 8'hE0;
	localparam logic [7:0] MASK_L4   = 8'hF8;
	localparam logic [7:0] TAG_L4    = 8'hF0;
	localparam logic [7:0] BITS_L2   = 8'h1F;
	localparam logic [7:0] BITS_L3   = 8'h0F;
	localparam logic [7:0] BITS_L4   = 8'h07;
	localparam logic [7:0] BITS_CONT = 8'h3F;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	// One decoded result.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            rep;
	} result_t;

	// Results caused by one input word; r0 always goes out first.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// Results gathered while one word is decoded.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} pend_t;

	// Outcome of decoding a byte as a fresh lead.
	typedef struct packed {
		logic            emit;
		result_t         res;
		logic [CP_W-1:0] pv;
		logic [1:0]      bse;
	} lead_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	function automatic result_t repl_result();
		result_t r;
		r.cp  = REPL_CP;
		r.rep = 1'b1;
		return r;
	endfunction

	// Append one result to the pending list.
	function automatic pend_t add_result(input pend_t p, input result_t r);
		pend_t o;
		o = p;
		if (p.cnt == 2'd0) begin
			o.r0 = r;
		end else begin
			o.r1 = r;
		end
		o.cnt = p.cnt + 2'd1;
		return o;
	endfunction

	// Decode a nonzero, non-continuation byte as the start of a character.
	function automatic lead_t decode_lead(input logic [7:0] b);
		lead_t l;
		l = '0;
		if (!b[7]) begin
			l.emit   = 1'b1;
			l.res.cp = {{(CP_W-8){1'b0}}, b};
		end else if ((b & MASK_L2) == TAG_L2) begin
			l.pv  = {{(CP_W-8){1'b0}}, b & BITS_L2};
			l.bse = 2'd1;
		end else if ((b & MASK_L3) == TAG_L3) begin
			l.pv  = {{(CP_W-8){1'b0}}, b & BITS_L3};
			l.bse = 2'd2;
		end else if ((b & MASK_L4) == TAG_L4) begin
			l.pv  = {{(CP_W-8){1'b0}}, b & BITS_L4};
			l.bse = 2'd3;
		end else begin
			l.emit = 1'b1;
			l.res  = repl_result();
		end
		return l;
	endfunction

endpackage

>>> sv/utf8d_front.sv
// Front end: accepts bytes, keeps the sequence state and forms the results of each word.
module utf8d_front import utf8d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   data_byte,
	input  logic         end_of_string,
	input  fifo_status_t fifo_st,
	output logic         push,
	output entry_t       push_entry
);

	logic [CP_W-1:0] pv_q;
	logic [1:0]      bse_q;
	logic            start_q;

	logic [CP_W-1:0] pv_n;
	logic [1:0]      bse_n;
	logic            start_n;
	pend_t           pend;
	lead_t           lead;
	logic            cont;
	logic [CP_W-1:0] pv_acc;
	result_t         acc_res;
	logic            accept;

	assign s_tready = !fifo_st.full;
	assign accept   = s_tvalid && s_tready;
	assign cont     = (data_byte & MASK_CONT) == CONT_TAG;
	assign pv_acc   = {pv_q[CP_W-7:0], data_byte[5:0] & BITS_CONT[5:0]};
	assign lead     = decode_lead(data_byte);
	assign acc_res  = '{cp: pv_acc, rep: 1'b0};

	// Decode one byte against the current sequence state.
	always_comb begin
		pend    = '0;
		pv_n    = pv_q;
		bse_n   = bse_q;
		start_n = 1'b0;
		if (data_byte == 8'd0) begin
			if (bse_q != 2'd0) begin
				pend = add_result(pend, repl_result());
			end
			pv_n    = '0;
			bse_n   = 2'd0;
			start_n = 1'b1;
		end else begin
			if (bse_q != 2'd0) begin
				if (cont) begin
					bse_n = bse_q - 2'd1;
					if (bse_n == 2'd0) begin
						pend = add_result(pend, acc_res);
						pv_n = '0;
					end else begin
						pv_n = pv_acc;
					end
				end else begin
					// A broken sequence is replaced, then the byte starts anew.
					pend = add_result(pend, repl_result());
					if (lead.emit) begin
						pend = add_result(pend, lead.res);
					end
					pv_n  = lead.pv;
					bse_n = lead.bse;
				end
			end else if (cont) begin
				if (start_q) begin
					pend = add_result(pend, repl_result());
				end
			end else begin
				if (lead.emit) begin
					pend = add_result(pend, lead.res);
				end
				pv_n  = lead.pv;
				bse_n = lead.bse;
			end
			if (end_of_string) begin
				if (bse_n != 2'd0) begin
					pend = add_result(pend, repl_result());
				end
				pv_n    = '0;
				bse_n   = 2'd0;
				start_n = 1'b1;
			end
		end
	end

	assign push          = accept && (pend.cnt != 2'd0);
	assign push_entry.two = pend.cnt[1];
	assign push_entry.r0  = pend.r0;
	assign push_entry.r1  = pend.r1;

	// Sequence state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			bse_q   <= 2'd0;
			start_q <= 1'b1;
		end else if (accept) begin
			pv_q    <= pv_n;
			bse_q   <= bse_n;
			start_q <= start_n;
		end
	end

endmodule

>>> sv/utf8d_fifo.sv
// Short queue of result entries between the front and back ends.
module utf8d_fifo import utf8d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  entry_t       push_entry,
	input  logic         pop,
	output entry_t       head,
	output fifo_status_t st
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign st.full  = count_q == CW'(DEPTH);
	assign st.empty = count_q == '0;
	assign head     = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> sv/utf8d_back.sv
// Back end: takes entries from the queue and sends their results one word at a time.
module utf8d_back import utf8d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  fifo_status_t        fifo_st,
	input  entry_t              head,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [CP_W-1:0]     code_point,
	output logic                replaced,
	output logic                last_of_item
);

	logic    valid_q;
	logic    phase_q;
	entry_t  ent_q;
	result_t cur;
	logic    done;

	assign cur          = phase_q ? ent_q.r1 : ent_q.r0;
	assign last_of_item = phase_q || !ent_q.two;
	assign code_point   = cur.cp;
	assign replaced     = cur.rep;
	assign m_tvalid     = valid_q;

	// The held entry is finished once its last result is taken.
	assign done = !valid_q || (m_tready && last_of_item);
	assign pop  = done && !fifo_st.empty;

	// Control of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (m_tready) begin
			phase_q <= 1'b1;
		end
	end

	// Held entry payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
	end

endmodule

>>> sv/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: front end, result queue and back end.
//
//  channel  | dir | tdata              | tuser    | tlast
//  ---------+-----+--------------------+----------+---------------
//  s_*      | in  | [7:0] data_byte    | -        | end_of_string
//  m_*      | out | [20:0] code_point  | replaced | last_of_item
//
// One byte is accepted per clock while the queue has room; results leave at one
// per clock from the output register while m_tready is high; a byte with two
// results sends two words. Input stalls only when the FIFO_DEPTH-entry queue is full.
// Reset clears the sequence state to the start of a string and empties the queue.
module utf8_stream_decoder_top import utf8d_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_tuser,   // [0] replaced
	output logic        m_tlast
);

	fifo_status_t    fifo_st;
	logic            push;
	entry_t          push_entry;
	logic            pop;
	entry_t          head;
	logic [CP_W-1:0] code_point;

	utf8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.data_byte     (s_tdata),
		.end_of_string (s_tlast),
		.fifo_st       (fifo_st),
		.push          (push),
		.push_entry    (push_entry)
	);

	utf8d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.st         (fifo_st)
	);

	utf8d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_st      (fifo_st),
		.head         (head),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.code_point   (code_point),
		.replaced     (m_tuser),
		.last_of_item (m_tlast)
	);

	assign m_tdata = {3'b000, code_point};

endmodule

>>> sv/utf8d_checker.sv
// Port-level checker for the UTF-8 stream decoder and its bind to the top level.
`include "utf8_stream_decoder_top_assert.svh"

module utf8d_checker import utf8d_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A replacement always carries U+FFFD.
	`U8D_ASSERT_IMPLY(a_repl_value, clk, arst_n, m_tvalid && m_tuser, m_tdata[20:0] == REPL_CP)

	// Padding above the code point stays zero.
	`U8D_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[23:21] == 3'b000)

	// Without an accepted input word the queue cannot fill, so ready stays up.
	`U8D_ASSERT_NEXT(a_ready_hold, clk, arst_n, s_tready && !s_tvalid, s_tready)

	// The second result of a byte follows its first with no gap.
	`U8D_ASSERT_NEXT(a_pair_back_to_back, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

	// A stalled result holds.
	`U8D_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind utf8_stream_decoder_top utf8d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
